[hw/rtl/ibst_pkg.sv]
// Shared types and constants for the servo and telemetry responder.
`timescale 1ns / 1ps
package ibst_pkg;
    localparam int NUM_CHANNELS = 14;
    localparam int FRAME_BYTES = 32;
    localparam int NUM_SENSORS = 6;
    localparam logic [7:0] LEN_SERVO = 8'd32;
    localparam logic [7:0] LEN_TELEM = 8'd4;
    localparam logic [3:0] CMD_DISCOVER = 4'h8;
    localparam logic [3:0] CMD_TYPE = 4'h9;
    localparam logic [3:0] CMD_MEASURE = 4'ha;
    localparam logic [2:0] ADDR_COG = 3'd2;

    // Job codes passed from the front part to the back part.
    localparam logic [1:0] JOB_SERVO = 2'd0;
    localparam logic [1:0] JOB_DISC = 2'd1;
    localparam logic [1:0] JOB_TYPE = 2'd2;
    localparam logic [1:0] JOB_MEAS = 2'd3;

    typedef struct packed {
        logic [1:0]  job;
        logic [2:0]  addr;
        logic [31:0] value;
    } t_job;

    function automatic logic [7:0] type_id(input logic [2:0] a);
        logic [7:0] r;
        case (a)
            3'd1: r = 8'h08;
            3'd2: r = 8'h0a;
            3'd3: r = 8'h13;
            3'd4: r = 8'h14;
            3'd5: r = 8'h80;
            default: r = 8'h81;
        endcase
        return r;
    endfunction

    function automatic logic [2:0] value_size(input logic [2:0] a);
        return (a >= 3'd5) ? 3'd4 : 3'd2;
    endfunction
endpackage

[hw/rtl/ibst_front.sv]
// Front part: frames link bytes, holds sensors and queues decoded jobs.
`timescale 1ns / 1ps
module ibst_front import ibst_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    output logic        o_full,
    input  logic        i_cmd,
    input  logic [7:0]  i_rx_byte,
    input  logic [2:0]  i_sensor_sel,
    input  logic [31:0] i_sensor_value,
    input  logic        i_sensor_ok,
    output logic        o_job_valid,
    output t_job        o_job,
    input  logic        i_job_take,
    input  logic [4:0]  i_rd_addr,
    output logic [7:0]  o_rd_data
);
    logic [7:0]  r_frame [FRAME_BYTES];
    logic [5:0]  r_count;
    logic [7:0]  r_head;
    logic [7:0]  r_query;
    logic [31:0] r_sens [NUM_SENSORS];
    logic [NUM_SENSORS-1:0] r_ok;
    t_job        r_q [2];
    logic        r_wp, r_rp;
    logic [1:0]  r_n;
    logic        r_servo_hold;
    logic        acc, job_push;
    t_job        new_job;
    logic [5:0]  n_count;
    logic [7:0]  head;
    logic [3:0]  addr4, cmdn;
    logic [2:0]  s;
    logic [31:0] v;
    logic        done;

    // A stored servo frame must stay until its job is drained.
    assign o_full = (r_n == 2'd2) || r_servo_hold;
    assign acc = i_push && !o_full;
    assign head = (r_count == 6'd0) ? i_rx_byte : r_head;
    assign n_count = r_count + 6'd1;
    assign done = (head == LEN_TELEM || head == LEN_SERVO) && ({2'b0, n_count} >= head);
    assign addr4 = r_query[3:0];
    assign cmdn = r_query[7:4];
    assign s = addr4[2:0] - 3'd1;

    always_comb begin
        v = r_ok[s] ? r_sens[s] : ((addr4[2:0] == ADDR_COG) ? 32'h0000ffff : 32'h0);
        new_job.addr = addr4[2:0];
        new_job.value = v;
        new_job.job = JOB_SERVO;
        job_push = 1'b0;
        if (acc && !i_cmd && done) begin
            if (head == LEN_SERVO) begin
                job_push = 1'b1;
            end else if (addr4 >= 4'd1 && addr4 <= 4'd6) begin
                job_push = (cmdn == CMD_DISCOVER) || (cmdn == CMD_TYPE)
                        || (cmdn == CMD_MEASURE);
                new_job.job = (cmdn == CMD_DISCOVER) ? JOB_DISC
                            : (cmdn == CMD_TYPE) ? JOB_TYPE : JOB_MEAS;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc && !i_cmd) begin
            r_frame[r_count[4:0]] <= i_rx_byte;
        end
        if (acc && !i_cmd && r_count == 6'd0) begin
            r_head <= i_rx_byte;
        end
        if (acc && !i_cmd && r_count == 6'd1) begin
            r_query <= i_rx_byte;
        end
        if (acc && i_cmd && i_sensor_sel >= 3'd1 && i_sensor_sel <= 3'd6) begin
            r_sens[i_sensor_sel - 3'd1] <= i_sensor_value;
        end
        if (job_push) begin
            r_q[r_wp] <= new_job;
        end
        o_rd_data <= r_frame[i_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_ok <= '0;
            r_wp <= 1'b0;
            r_rp <= 1'b0;
            r_n <= '0;
            r_servo_hold <= 1'b0;
        end else begin
            if (acc && i_cmd && i_sensor_sel >= 3'd1 && i_sensor_sel <= 3'd6) begin
                r_ok[i_sensor_sel - 3'd1] <= i_sensor_ok;
            end
            if (acc && !i_cmd) begin
                r_count <= (done || !(head == LEN_TELEM || head == LEN_SERVO)) ? 6'd0 : n_count;
            end
            if (job_push) begin
                r_wp <= !r_wp;
            end
            if (i_job_take) begin
                r_rp <= !r_rp;
            end
            r_n <= r_n + {1'b0, job_push} - {1'b0, i_job_take};
            if (job_push && new_job.job == JOB_SERVO) begin
                r_servo_hold <= 1'b1;
            end else if (i_job_take && r_q[r_rp].job == JOB_SERVO) begin
                r_servo_hold <= 1'b0;
            end
        end
    end

    assign o_job_valid = (r_n != 2'd0);
    assign o_job = r_q[r_rp];

    assert property (@(posedge i_clk) disable iff (!i_rst_n) r_n <= 2'd2)
        else $error("job queue overfilled");
    assert property (@(posedge i_clk) disable iff (!i_rst_n) i_job_take |-> o_job_valid)
        else $error("job taken from an empty queue");
    assert property (@(posedge i_clk) disable iff (!i_rst_n) r_servo_hold |-> o_full)
        else $error("input accepted while a servo frame is pending");
endmodule

[hw/rtl/ibst_back.sv]
// Back part: turns jobs into servo words or reply bytes, one job at a time.
`timescale 1ns / 1ps
module ibst_back import ibst_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_job_valid,
    input  t_job        i_job,
    output logic        o_job_take,
    output logic [4:0]  o_rd_addr,
    input  logic [7:0]  i_rd_data,
    output logic        o_empty,
    input  logic        i_pop,
    output logic        o_kind,
    output logic [7:0]  o_tx_byte,
    output logic [3:0]  o_channel_index,
    output logic [15:0] o_channel_value,
    output logic        o_last
);
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_LO = 2'd1;
    localparam logic [1:0] ST_HI = 2'd2;
    localparam logic [1:0] ST_TX = 2'd3;

    logic [1:0]  r_st;
    logic [3:0]  r_idx;
    logic [2:0]  r_total;
    logic [7:0]  r_lo;
    logic [15:0] r_sum;
    logic        r_full;
    logic [7:0]  bytev [8];
    logic [7:0]  pay;
    logic [2:0]  plen;
    logic        slot;

    assign slot = !r_full || i_pop;
    assign o_empty = !r_full;
    assign o_job_take = i_job_valid && (r_st == ST_IDLE) && (i_job.job != JOB_SERVO)
                        ? 1'b0 : (r_st == ST_HI && slot && r_idx == 4'(NUM_CHANNELS - 1))
                        || (r_st == ST_TX && slot && r_idx[2:0] == r_total - 3'd1);
    // The read data is registered and arrives in the cycle after its address, so each address
    // is issued one state ahead; a stalled high-byte state keeps its address to hold the data.
    assign o_rd_addr = (r_st == ST_LO) ? 5'(2 * r_idx + 3)
                     : (r_st == ST_HI && slot) ? 5'(2 * r_idx + 4)
                     : (r_st == ST_HI) ? 5'(2 * r_idx + 3) : 5'd2;

    always_comb begin
        plen = (i_job.job == JOB_DISC) ? 3'd1 : (i_job.job == JOB_TYPE) ? 3'd3
             : 3'd1 + value_size(i_job.addr);
        bytev[0] = {5'd0, plen} + 8'd3;
        bytev[1] = {(i_job.job == JOB_DISC) ? CMD_DISCOVER : (i_job.job == JOB_TYPE)
                    ? CMD_TYPE : CMD_MEASURE, 1'b0, i_job.addr};
        bytev[2] = (i_job.job == JOB_TYPE) ? type_id(i_job.addr) : i_job.value[7:0];
        bytev[3] = (i_job.job == JOB_TYPE) ? {5'd0, value_size(i_job.addr)}
                                           : i_job.value[15:8];
        bytev[4] = i_job.value[23:16];
        bytev[5] = i_job.value[31:24];
        bytev[6] = 8'd0;
        bytev[7] = 8'd0;
        pay = 8'd0;
        if (r_idx[2:0] == r_total - 3'd2) begin
            pay = r_sum[7:0];
        end else if (r_idx[2:0] == r_total - 3'd1) begin
            pay = r_sum[15:8];
        end else begin
            pay = bytev[r_idx[2:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= ST_IDLE;
            r_full <= 1'b0;
            r_idx <= '0;
        end else begin
            if (i_pop && r_full) begin
                r_full <= 1'b0;
            end
            unique case (r_st)
                ST_IDLE: begin
                    r_idx <= '0;
                    if (i_job_valid) begin
                        r_st <= (i_job.job == JOB_SERVO) ? ST_LO : ST_TX;
                        r_total <= plen + 3'd3;
                        r_sum <= 16'hffff - {13'd0, plen} - 16'd3;
                    end
                end
                ST_LO: begin
                    r_st <= ST_HI;
                end
                ST_HI: begin
                    r_lo <= r_lo;
                    if (slot) begin
                        r_full <= 1'b1;
                        o_kind <= 1'b1;
                        o_tx_byte <= 8'd0;
                        o_channel_index <= r_idx;
                        o_channel_value <= {i_rd_data, r_lo};
                        o_last <= (r_idx == 4'(NUM_CHANNELS - 1));
                        r_idx <= r_idx + 4'd1;
                        r_st <= (r_idx == 4'(NUM_CHANNELS - 1)) ? ST_IDLE : ST_LO;
                    end
                end
                ST_TX: begin
                    if (slot) begin
                        r_full <= 1'b1;
                        o_kind <= 1'b0;
                        o_tx_byte <= pay;
                        o_channel_index <= 4'd0;
                        o_channel_value <= 16'd0;
                        o_last <= (r_idx[2:0] == r_total - 3'd1);
                        if (r_idx != 4'd0 && r_idx[2:0] < r_total - 3'd2) begin
                            r_sum <= r_sum - {8'd0, pay};
                        end
                        r_idx <= r_idx + 4'd1;
                        if (r_idx[2:0] == r_total - 3'd1) begin
                            r_st <= ST_IDLE;
                        end
                    end
                end
                default: r_st <= ST_IDLE;
            endcase
        end
        if (r_st == ST_LO) begin
            r_lo <= i_rd_data;
        end
    end

    // An eight-byte reply wraps the three-bit total to zero.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == ST_TX) |-> (r_total >= 3'd4 || r_total == 3'd0))
        else $error("reply shorter than four bytes");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == ST_HI) |-> (r_idx < 4'(NUM_CHANNELS)))
        else $error("servo channel index out of range");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_job_take |-> (r_st == ST_HI || r_st == ST_TX))
        else $error("job released while idle");
endmodule

[hw/rtl/ibus_servo_telemetry_responder_unit.sv]
// Top level of the servo and telemetry responder.
//   channel  | direction | handshake
//   input    | in        | i_push / o_full
//   result   | out       | o_empty / i_pop
// A link byte or sensor update is taken while o_full is low; a servo frame gives 14 words,
// each read from frame memory as a low then a high byte, and a reply 4 to 8 bytes at one
// per cycle while results are popped. While a servo frame waits to be sent, input is held
// off. Reset is synchronous and clears framing, sensor flags and the job queue.
`timescale 1ns / 1ps
module ibus_servo_telemetry_responder_unit import ibst_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    output logic        o_full,
    input  logic        i_cmd,
    input  logic [7:0]  i_rx_byte,
    input  logic [2:0]  i_sensor_sel,
    input  logic [31:0] i_sensor_value,
    input  logic        i_sensor_ok,
    output logic        o_empty,
    input  logic        i_pop,
    output logic        o_kind,
    output logic [7:0]  o_tx_byte,
    output logic [3:0]  o_channel_index,
    output logic [15:0] o_channel_value,
    output logic        o_last
);
    logic       job_valid, job_take;
    t_job       job;
    logic [4:0] rd_addr;
    logic [7:0] rd_data;

    ibst_front u_front (
        .i_clk, .i_rst_n, .i_push, .o_full, .i_cmd, .i_rx_byte, .i_sensor_sel,
        .i_sensor_value, .i_sensor_ok, .o_job_valid(job_valid), .o_job(job),
        .i_job_take(job_take), .i_rd_addr(rd_addr), .o_rd_data(rd_data)
    );

    ibst_back u_back (
        .i_clk, .i_rst_n, .i_job_valid(job_valid), .i_job(job), .o_job_take(job_take),
        .o_rd_addr(rd_addr), .i_rd_data(rd_data), .o_empty, .i_pop, .o_kind,
        .o_tx_byte, .o_channel_index, .o_channel_value, .o_last
    );
endmodule
